// ===== hw/rtl/pdot_pkg.sv =====
// shared types, widths and action decode for the packed dot accumulate block
package pdot_pkg;

  localparam int DATA_W   = 32;
  localparam int ACTION_W = 3;

  // lane width select, taken from action bits 2..1
  typedef enum logic [1:0] {
    LW_16 = 2'd0,
    LW_8  = 2'd1,
    LW_4  = 2'd2,
    LW_2  = 2'd3
  } lane_w_t;

  // operation mode handed to the datapath
  typedef struct packed {
    lane_w_t lane_w;
    logic    is_unsigned;
  } pdot_mode_t;

  // split the action code into lane width and signedness
  function automatic pdot_mode_t decode_action(input logic [ACTION_W-1:0] action);
    pdot_mode_t m;
    m.lane_w      = lane_w_t'(action[2:1]);
    m.is_unsigned = action[0];
    return m;
  endfunction

endpackage

// ===== hw/rtl/pdot_mac.sv =====
// lane multipliers, per-width product sums and accumulator add
module pdot_mac (
  input  pdot_pkg::pdot_mode_t          mode,
  input  logic [pdot_pkg::DATA_W-1:0]   operand_a,
  input  logic [pdot_pkg::DATA_W-1:0]   operand_b,
  input  logic [pdot_pkg::DATA_W-1:0]   accumulator_in,
  output logic [pdot_pkg::DATA_W-1:0]   dot_result
);

  logic               ext_en;

  logic signed [16:0] a16 [2];
  logic signed [16:0] b16 [2];
  logic signed [33:0] p16 [2];
  logic        [31:0] sum16;

  logic signed [8:0]  a8 [4];
  logic signed [8:0]  b8 [4];
  logic signed [17:0] p8 [4];
  logic signed [19:0] sum8;

  logic signed [4:0]  a4 [8];
  logic signed [4:0]  b4 [8];
  logic signed [9:0]  p4 [8];
  logic signed [12:0] sum4;

  logic signed [2:0]  a2 [16];
  logic signed [2:0]  b2 [16];
  logic signed [5:0]  p2 [16];
  logic signed [6:0]  pair2 [8];
  logic signed [9:0]  sum2;

  logic [31:0]        lane_sum;

  // lanes get a sign bit only in signed modes
  assign ext_en = ~mode.is_unsigned;

  // 16-bit lanes, product wraps to 32 bits
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      a16[i] = {ext_en & operand_a[16*i+15], operand_a[16*i +: 16]};
      b16[i] = {ext_en & operand_b[16*i+15], operand_b[16*i +: 16]};
      p16[i] = a16[i] * b16[i];
    end
    sum16 = p16[0][31:0] + p16[1][31:0];
  end

  // 8-bit lanes
  always_comb begin
    sum8 = '0;
    for (int i = 0; i < 4; i++) begin
      a8[i] = {ext_en & operand_a[8*i+7], operand_a[8*i +: 8]};
      b8[i] = {ext_en & operand_b[8*i+7], operand_b[8*i +: 8]};
      p8[i] = a8[i] * b8[i];
    end
    for (int i = 0; i < 4; i++) begin
      sum8 = sum8 + 20'(p8[i]);
    end
  end

  // 4-bit lanes
  always_comb begin
    sum4 = '0;
    for (int i = 0; i < 8; i++) begin
      a4[i] = {ext_en & operand_a[4*i+3], operand_a[4*i +: 4]};
      b4[i] = {ext_en & operand_b[4*i+3], operand_b[4*i +: 4]};
      p4[i] = a4[i] * b4[i];
    end
    for (int i = 0; i < 8; i++) begin
      sum4 = sum4 + 13'(p4[i]);
    end
  end

  // 2-bit lanes, summed in pairs first
  always_comb begin
    sum2 = '0;
    for (int i = 0; i < 16; i++) begin
      a2[i] = {ext_en & operand_a[2*i+1], operand_a[2*i +: 2]};
      b2[i] = {ext_en & operand_b[2*i+1], operand_b[2*i +: 2]};
      p2[i] = a2[i] * b2[i];
    end
    for (int i = 0; i < 8; i++) begin
      pair2[i] = 7'(p2[2*i]) + 7'(p2[2*i+1]);
    end
    for (int i = 0; i < 8; i++) begin
      sum2 = sum2 + 10'(pair2[i]);
    end
  end

  // pick the sum for the lane width, sign-extended to the word
  always_comb begin
    case (mode.lane_w)
      pdot_pkg::LW_16: lane_sum = sum16;
      pdot_pkg::LW_8:  lane_sum = 32'(sum8);
      pdot_pkg::LW_4:  lane_sum = 32'(sum4);
      pdot_pkg::LW_2:  lane_sum = 32'(sum2);
      default:         lane_sum = '0;
    endcase
  end

  // accumulate, wraps modulo 2^32
  assign dot_result = accumulator_in + lane_sum;

endmodule

// ===== hw/rtl/packed_simd_dot_accumulate.sv =====
// A request accepted into the input register moves on to the result register once that
// register is free, and its result is taken from there while out_ready is high.
// Throughput: one request per cycle; the input and result registers each
// stall only when the stage after them is full and not taken.
// Reset (rst_n low, synchronous) clears both stage valid flags; the data
// registers are not reset, so the block is ready at the first cycle after reset.
module packed_simd_dot_accumulate (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [pdot_pkg::ACTION_W-1:0]      in_action,
  input  logic [pdot_pkg::DATA_W-1:0]        in_operand_a,
  input  logic [pdot_pkg::DATA_W-1:0]        in_operand_b,
  input  logic [pdot_pkg::DATA_W-1:0]        in_accumulator_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pdot_pkg::DATA_W-1:0]        out_dot_result
);

  logic                              s1_valid_r;
  logic [pdot_pkg::ACTION_W-1:0]     s1_action_r;
  logic [pdot_pkg::DATA_W-1:0]       s1_a_r;
  logic [pdot_pkg::DATA_W-1:0]       s1_b_r;
  logic [pdot_pkg::DATA_W-1:0]       s1_acc_r;

  logic                              out_valid_r;
  logic [pdot_pkg::DATA_W-1:0]       out_result_r;

  logic                              s2_free;
  logic                              s2_load;
  logic                              s1_load;
  pdot_pkg::pdot_mode_t              mode;
  logic [pdot_pkg::DATA_W-1:0]       mac_result;

  // stage handshakes
  assign s2_free  = ~out_valid_r | out_ready;
  assign s2_load  = s1_valid_r & s2_free;
  assign in_ready = ~s1_valid_r | s2_free;
  assign s1_load  = in_valid & in_ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (s1_load) begin
      s1_action_r <= in_action;
      s1_a_r      <= in_operand_a;
      s1_b_r      <= in_operand_b;
      s1_acc_r    <= in_accumulator_in;
    end
  end

  // datapath
  assign mode = pdot_pkg::decode_action(s1_action_r);

  pdot_mac u_mac (
    .mode           (mode),
    .operand_a      (s1_a_r),
    .operand_b      (s1_b_r),
    .accumulator_in (s1_acc_r),
    .dot_result     (mac_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_free) begin
      out_valid_r <= s1_valid_r;
    end
    if (s2_load) begin
      out_result_r <= mac_result;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_dot_result = out_result_r;

  // assertions
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid_r && !s1_valid_r)
    else $error("stage valid set right after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input stalled with room in the pipeline");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s2_load |=> out_valid_r && out_result_r == $past(mac_result))
    else $error("result register missed an advancing request");

  a_held_request: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_free |=> s1_valid_r && $stable(s1_a_r) && $stable(s1_b_r))
    else $error("stalled request lost from input register");

endmodule
